>>> design/subreflector_move_path_delta_defines.svh
// Assertion helpers for the subreflector_move_path_delta design file.
`ifndef SUBREFLECTOR_MOVE_PATH_DELTA_DEFINES_SVH
`define SUBREFLECTOR_MOVE_PATH_DELTA_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define SMPD_ASSERT_NOW(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define SMPD_ASSERT_NEXT(name, cond, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

>>> design/smpd_pkg.sv
package smpd_pkg;

   // Six ratios: Z, Y, X of the primary frame, then Z, Y, X of the Gregorian frame
   localparam int NUM_RATIOS = 6;
   localparam int DIV_STEPS  = 32;
   localparam int DEN_W      = 51;
   localparam int NUM_W      = DEN_W + 1;
   localparam int Q_W        = 32;
   localparam int CQ_W       = 32;
   localparam int ZR_W       = 34;
   localparam int ROT_W      = 64;
   localparam int PROD_W     = 66;
   localparam int FRAME_W    = 68;
   localparam int OUT_W      = 35;

   // Register indexes
   localparam logic [2:0] REG_SHIFT_X    = 3'd0;
   localparam logic [2:0] REG_SHIFT_Y    = 3'd1;
   localparam logic [2:0] REG_SHIFT_Z    = 3'd2;
   localparam logic [2:0] REG_FOCAL_PRIM = 3'd3;
   localparam logic [2:0] REG_FOCAL_GREG = 3'd4;

   localparam logic [23:0] FOCAL_PRIM_RESET = 24'd3932160;
   localparam logic [23:0] FOCAL_GREG_RESET = 24'd12451840;

   // Q30 rotation constants (36.7 and 24.37 degrees)
   localparam logic signed [31:0] COS_PRIM = 32'sd860900043;
   localparam logic signed [31:0] SIN_PRIM = 32'sd641695115;
   localparam logic signed [31:0] COS_GREG = 32'sd978071252;
   localparam logic signed [31:0] SIN_GREG = 32'sd443055447;

   // 54 m offset of the primary frame, units 2^-16 m
   localparam logic signed [24:0] PRIM_Y_OFFS = 25'sd3538944;

   localparam logic signed [CQ_W-1:0]    Q30_ONE    = 32'sd1073741824;
   localparam logic signed [FRAME_W-1:0] ROUND_HALF = 68'sd536870912;
   localparam logic signed [FRAME_W-1:0] OUT_MAX    = 68'sd17179869183;
   localparam logic signed [FRAME_W-1:0] OUT_MIN    = -68'sd17179869184;

   typedef struct packed {
      logic                              valid;
      logic [1:0]                        zero;
      logic [NUM_RATIOS-1:0]             neg;
      logic [1:0][DEN_W-1:0]             den;
      logic [NUM_RATIOS-1:0][DEN_W-1:0]  rem;
      logic [NUM_RATIOS-1:0][Q_W-1:0]    q;
   } div_stage_type;

   typedef struct packed {
      logic                              valid;
      logic [NUM_RATIOS-1:0][CQ_W-1:0]   c;
   } ratio_stage_type;

   // Magnitude of a signed numerator
   function automatic logic [DEN_W-1:0] num_mag(input logic signed [NUM_W-1:0] v);
      logic signed [NUM_W-1:0] a;
      a = v[NUM_W-1] ? -v : v;
      return a[DEN_W-1:0];
   endfunction

   // One restoring step for all six ratios; the first step does not shift
   function automatic div_stage_type div_step(input div_stage_type s, input logic first);
      div_stage_type r;
      logic [DEN_W:0] t;
      logic [DEN_W:0] d;
      r = s;
      for (int i = 0; i < NUM_RATIOS; i++) begin
         t = first ? {1'b0, s.rem[i]} : {s.rem[i], 1'b0};
         d = (i < 3) ? {1'b0, s.den[0]} : {1'b0, s.den[1]};
         if (t >= d) begin
            r.rem[i] = DEN_W'(t - d);
            r.q[i]   = {s.q[i][Q_W-2:0], 1'b1};
         end else begin
            r.rem[i] = t[DEN_W-1:0];
            r.q[i]   = {s.q[i][Q_W-2:0], 1'b0};
         end
      end
      return r;
   endfunction

endpackage

>>> design/subreflector_move_path_delta.sv
// Channel | Port group | Word contents
// input   | req_*      | tdata: point_x [23:0], point_y [47:24]
// output  | rsp_*      | tdata: path_delta [34:0], zeros [39:35]
// config  | csr_*      | APB, registers at 4*i: shift_x/y/z, primary/gregorian focal length
// One point enters per cycle while the output is not stalled; path_delta comes out of
// the last of 40 register stages, the first of which takes the point.
// The six Q30 ratios are formed by a restoring divider: a load stage, then 32 steps.
// Synchronous active-high reset clears the valid bits and loads the register defaults.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
`include "subreflector_move_path_delta_defines.svh"

module subreflector_move_path_delta
   import smpd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,    // point_x [23:0], point_y [47:24]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,    // path_delta [34:0], zero pad [39:35]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic adv;

   // configuration registers
   logic signed [31:0] shift_x_ff, shift_y_ff, shift_z_ff;
   logic [23:0]        focal_p_ff, focal_g_ff;
   logic               csr_wr;

   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_x_ff <= '0;
         shift_y_ff <= '0;
         shift_z_ff <= '0;
         focal_p_ff <= FOCAL_PRIM_RESET;
         focal_g_ff <= FOCAL_GREG_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[4:2])
            REG_SHIFT_X:    shift_x_ff <= $signed(csr_pwdata);
            REG_SHIFT_Y:    shift_y_ff <= $signed(csr_pwdata);
            REG_SHIFT_Z:    shift_z_ff <= $signed(csr_pwdata);
            REG_FOCAL_PRIM: focal_p_ff <= csr_pwdata[23:0];
            REG_FOCAL_GREG: focal_g_ff <= csr_pwdata[23:0];
            default: ;
         endcase
      end
   end

   // register readback
   always_comb begin
      case (csr_paddr[4:2])
         REG_SHIFT_X:    csr_prdata = shift_x_ff;
         REG_SHIFT_Y:    csr_prdata = shift_y_ff;
         REG_SHIFT_Z:    csr_prdata = shift_z_ff;
         REG_FOCAL_PRIM: csr_prdata = {8'd0, focal_p_ff};
         REG_FOCAL_GREG: csr_prdata = {8'd0, focal_g_ff};
         default:        csr_prdata = '0;
      endcase
   end

   // advance the whole pipeline unless the output word waits
   logic             rsp_valid_ff;
   logic [OUT_W-1:0] rsp_data_ff;

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;

   // rotated shifts, refreshed every cycle from the registers
   logic signed [ROT_W-1:0] rot_ff [8];
   logic signed [ZR_W-1:0]  zr_p_ff, yr_p_ff, zr_g_ff, yr_g_ff;
   logic signed [ROT_W+1:0] zr_p_sum, yr_p_sum, zr_g_sum, yr_g_sum;

   always_ff @(posedge clock) begin
      rot_ff[0] <= shift_y_ff * COS_PRIM;
      rot_ff[1] <= shift_x_ff * SIN_PRIM;
      rot_ff[2] <= shift_x_ff * COS_PRIM;
      rot_ff[3] <= shift_y_ff * SIN_PRIM;
      rot_ff[4] <= shift_y_ff * COS_GREG;
      rot_ff[5] <= shift_x_ff * SIN_GREG;
      rot_ff[6] <= shift_x_ff * COS_GREG;
      rot_ff[7] <= shift_y_ff * SIN_GREG;
   end

   assign zr_p_sum = (ROT_W+2)'(rot_ff[0]) + (ROT_W+2)'(rot_ff[1]) + (ROT_W+2)'(ROUND_HALF);
   assign yr_p_sum = (ROT_W+2)'(rot_ff[2]) - (ROT_W+2)'(rot_ff[3]) + (ROT_W+2)'(ROUND_HALF);
   assign zr_g_sum = (ROT_W+2)'(rot_ff[4]) + (ROT_W+2)'(rot_ff[5]) + (ROT_W+2)'(ROUND_HALF);
   assign yr_g_sum = (ROT_W+2)'(rot_ff[6]) - (ROT_W+2)'(rot_ff[7]) + (ROT_W+2)'(ROUND_HALF);

   always_ff @(posedge clock) begin
      zr_p_ff <= zr_p_sum[30 +: ZR_W];
      yr_p_ff <= yr_p_sum[30 +: ZR_W];
      zr_g_ff <= zr_g_sum[30 +: ZR_W];
      yr_g_ff <= yr_g_sum[30 +: ZR_W];
   end

   // stage 1: take the point, form the frame coordinates
   logic                s1_valid_ff;
   logic signed [23:0]  s1_x_ff;
   logic signed [24:0]  s1_ryp_ff, s1_ryg_ff;
   logic signed [24:0]  y_ext;

   assign y_ext = {req_tdata[47], req_tdata[47:24]};

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_tvalid;
         s1_x_ff     <= $signed(req_tdata[23:0]);
         s1_ryp_ff   <= y_ext + PRIM_Y_OFFS;
         s1_ryg_ff   <= -y_ext;
      end
   end

   // stage 2: squares and numerator products
   logic                    s2_valid_ff;
   logic signed [47:0]      s2_rxx_ff;
   logic signed [49:0]      s2_ryyp_ff, s2_ryyg_ff;
   logic [47:0]             s2_ffp_ff, s2_ffg_ff;
   logic signed [NUM_W-1:0] s2_nyp_ff, s2_nxp_ff, s2_nyg_ff, s2_nxg_ff;
   logic signed [26:0]      four_fp, four_fg;

   assign four_fp = $signed({1'b0, focal_p_ff, 2'b00});
   assign four_fg = $signed({1'b0, focal_g_ff, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
         s2_rxx_ff   <= s1_x_ff * s1_x_ff;
         s2_ryyp_ff  <= s1_ryp_ff * s1_ryp_ff;
         s2_ryyg_ff  <= s1_ryg_ff * s1_ryg_ff;
         s2_ffp_ff   <= focal_p_ff * focal_p_ff;
         s2_ffg_ff   <= focal_g_ff * focal_g_ff;
         s2_nyp_ff   <= four_fp * s1_ryp_ff;
         s2_nxp_ff   <= four_fp * s1_x_ff;
         s2_nyg_ff   <= four_fg * s1_ryg_ff;
         s2_nxg_ff   <= four_fg * s1_x_ff;
      end
   end

   // stage 3: denominators and Z numerators
   logic                    s3_valid_ff;
   logic [1:0][DEN_W-1:0]   s3_den_ff;
   logic signed [NUM_W-1:0] s3_num_ff [NUM_RATIOS];
   logic [DEN_W-1:0]        r2_p, r2_g, f4_p, f4_g;

   assign r2_p = DEN_W'(s2_rxx_ff[46:0]) + DEN_W'(s2_ryyp_ff[48:0]);
   assign r2_g = DEN_W'(s2_rxx_ff[46:0]) + DEN_W'(s2_ryyg_ff[48:0]);
   assign f4_p = DEN_W'({s2_ffp_ff, 2'b00});
   assign f4_g = DEN_W'({s2_ffg_ff, 2'b00});

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff  <= s2_valid_ff;
         s3_den_ff[0] <= f4_p + r2_p;
         s3_den_ff[1] <= f4_g + r2_g;
         s3_num_ff[0] <= $signed({1'b0, f4_p}) - $signed({1'b0, r2_p});
         s3_num_ff[1] <= s2_nyp_ff;
         s3_num_ff[2] <= s2_nxp_ff;
         s3_num_ff[3] <= $signed({1'b0, f4_g}) - $signed({1'b0, r2_g});
         s3_num_ff[4] <= s2_nyg_ff;
         s3_num_ff[5] <= s2_nxg_ff;
      end
   end

   // divider: load magnitudes, then one quotient bit per stage
   div_stage_type div_ff [DIV_STEPS+1];
   div_stage_type div_in [DIV_STEPS+1];

   always_comb begin
      div_in[0].valid = s3_valid_ff;
      div_in[0].den   = s3_den_ff;
      div_in[0].zero  = {s3_den_ff[1] == '0, s3_den_ff[0] == '0};
      for (int i = 0; i < NUM_RATIOS; i++) begin
         div_in[0].rem[i] = num_mag(s3_num_ff[i]);
         div_in[0].neg[i] = s3_num_ff[i][NUM_W-1];
         div_in[0].q[i]   = '0;
      end
   end

   for (genvar k = 0; k <= DIV_STEPS; k++) begin : g_div
      if (k > 0) begin : g_step
         assign div_in[k] = div_step(div_ff[k-1], k == 1);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[k].valid <= 1'b0;
         end else if (adv) begin
            div_ff[k] <= div_in[k];
         end
      end
   end

   // round the quotients to Q30 and apply signs; on-axis frames take Z in full
   ratio_stage_type ratio_ff, ratio_in;
   logic [Q_W:0]    q_inc [NUM_RATIOS];

   always_comb begin
      ratio_in.valid = div_ff[DIV_STEPS].valid;
      for (int i = 0; i < NUM_RATIOS; i++) begin
         q_inc[i] = {1'b0, div_ff[DIV_STEPS].q[i]} + 1'b1;
         if (div_ff[DIV_STEPS].zero[(i < 3) ? 0 : 1]) begin
            ratio_in.c[i] = (i == 0 || i == 3) ? Q30_ONE : '0;
         end else if (div_ff[DIV_STEPS].neg[i]) begin
            ratio_in.c[i] = -q_inc[i][Q_W:1];
         end else begin
            ratio_in.c[i] = q_inc[i][Q_W:1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ratio_ff.valid <= 1'b0;
      end else if (adv) begin
         ratio_ff <= ratio_in;
      end
   end

   // weight the rotated shifts by the ratios
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff [NUM_RATIOS];

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (adv) begin
         prod_valid_ff <= ratio_ff.valid;
         prod_ff[0]    <= zr_p_ff * $signed(ratio_ff.c[0]);
         prod_ff[1]    <= yr_p_ff * $signed(ratio_ff.c[1]);
         prod_ff[2]    <= shift_z_ff * $signed(ratio_ff.c[2]);
         prod_ff[3]    <= zr_g_ff * $signed(ratio_ff.c[3]);
         prod_ff[4]    <= yr_g_ff * $signed(ratio_ff.c[4]);
         prod_ff[5]    <= shift_z_ff * $signed(ratio_ff.c[5]);
      end
   end

   // frame sums: lateral terms subtract in the primary frame
   logic                      frame_valid_ff;
   logic signed [FRAME_W-1:0] prim_ff, greg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_valid_ff <= 1'b0;
      end else if (adv) begin
         frame_valid_ff <= prod_valid_ff;
         prim_ff <= FRAME_W'(prod_ff[0]) - FRAME_W'(prod_ff[1]) - FRAME_W'(prod_ff[2]);
         greg_ff <= FRAME_W'(prod_ff[3]) + FRAME_W'(prod_ff[4]) + FRAME_W'(prod_ff[5]);
      end
   end

   // round once to 2^-30 and saturate into the output word
   logic signed [FRAME_W-1:0] total, rounded;
   logic [OUT_W-1:0]          rsp_data_in;

   assign total   = prim_ff + greg_ff + ROUND_HALF;
   assign rounded = total >>> 30;

   always_comb begin
      if (rounded > OUT_MAX) begin
         rsp_data_in = OUT_MAX[OUT_W-1:0];
      end else if (rounded < OUT_MIN) begin
         rsp_data_in = OUT_MIN[OUT_W-1:0];
      end else begin
         rsp_data_in = rounded[OUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= frame_valid_ff;
         rsp_data_ff  <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff};

   // checks
   `SMPD_ASSERT_NEXT(a_div_hold, !adv, $stable(div_ff[DIV_STEPS].valid),
      "divider output moved during a stall")

   `SMPD_ASSERT_NEXT(a_out_load, adv && frame_valid_ff, rsp_tvalid,
      "frame sum lost on its way to the output")

   for (genvar i = 0; i < NUM_RATIOS; i++) begin : g_chk
      `SMPD_ASSERT_NOW(a_ratio_range, ratio_ff.valid,
         ($signed(ratio_ff.c[i]) <= Q30_ONE) && ($signed(ratio_ff.c[i]) >= -Q30_ONE),
         "ratio outside unit range")
   end

endmodule
